>>> rtl/lap3x3_pkg.sv
package lap3x3_pkg;

  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 16;
  localparam int IMG_W_BITS   = 12;
  localparam int IMG_H_BITS   = 13;
  localparam int ROW_W        = 13;
  localparam int X_W          = 11;
  localparam int Y_W          = 12;
  localparam int MAX_HEIGHT   = 4096;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;
  localparam int ROW_MAX      = 8191;
  localparam int FIFO_DEPTH   = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 4'd0,
    CFG_IMAGE_HEIGHT = 4'd1
  } cfg_reg_t;

  typedef struct packed {
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } mask_t;

  typedef struct packed {
    logic           res;
    logic           last;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
  } tag_t;

endpackage

>>> rtl/lap3x3_ifs.sv
interface lap3x3_in_if #(parameter int PIXEL_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [PIXEL_BITS-1:0] pixel_value;
  logic                         pad;

  modport source (output valid, output pixel_value, output pad, input ready);
  modport sink   (input valid, input pixel_value, input pad, output ready);
endinterface

interface lap3x3_out_if #(parameter int OUT_BITS = 21);
  logic                              valid;
  logic                              ready;
  logic signed [OUT_BITS-1:0]        filtered_value;
  logic [lap3x3_pkg::X_W-1:0]        out_x;
  logic [lap3x3_pkg::Y_W-1:0]        out_y;
  logic                              frame_last;

  modport source (output valid, output filtered_value, output out_x, output out_y,
                  output frame_last, input ready);
  modport sink   (input valid, input filtered_value, input out_x, input out_y,
                  input frame_last, output ready);
endinterface

interface lap3x3_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lap3x3_pkg::CFG_IDX_W-1:0]    index;
  logic [lap3x3_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/lap3x3_line_buf.sv
module lap3x3_line_buf #(
  parameter int DEPTH = 2048,
  parameter int PW    = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic signed [PW-1:0] wr_pixel,
  output logic signed [PW-1:0] older_o,
  output logic signed [PW-1:0] newer_o
);

  logic signed [PW-1:0] mem_older [DEPTH];
  logic signed [PW-1:0] mem_newer [DEPTH];

  logic signed [PW-1:0] rd_older_r;
  logic signed [PW-1:0] rd_newer_r;
  logic                 fwd_valid_r;
  logic [AW-1:0]        fwd_addr_r;
  logic signed [PW-1:0] fwd_older_r;
  logic signed [PW-1:0] fwd_newer_r;
  logic                 hit;

  // a read issued on the same edge as the previous write misses it
  always_comb begin
    hit     = fwd_valid_r && (fwd_addr_r == wr_addr);
    older_o = hit ? fwd_older_r : rd_older_r;
    newer_o = hit ? fwd_newer_r : rd_newer_r;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_older_r <= mem_older[rd_addr];
      rd_newer_r <= mem_newer[rd_addr];
    end
    if (wr_en) begin
      mem_older[wr_addr] <= newer_o;
      mem_newer[wr_addr] <= wr_pixel;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r  <= wr_addr;
    fwd_older_r <= newer_o;
    fwd_newer_r <= wr_pixel;
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else begin
      fwd_valid_r <= wr_en;
    end
  end

endmodule

>>> rtl/lap3x3_window.sv
module lap3x3_window #(
  parameter int PW = 16,
  parameter int OW = PW + 5
) (
  input  logic                 clk,
  input  logic                 shift_en,
  input  logic signed [PW-1:0] col_older,
  input  logic signed [PW-1:0] col_newer,
  input  logic signed [PW-1:0] col_pixel,
  input  lap3x3_pkg::mask_t    mask,
  output logic signed [OW-1:0] sum_o
);

  logic signed [PW-1:0] tap_r [3][3];
  logic signed [PW-1:0] m [3][3];
  logic signed [PW+1:0] corner_nxt;
  logic signed [PW+1:0] edge_nxt;
  logic signed [PW+1:0] corner_r;
  logic signed [PW+1:0] edge_r;
  logic signed [PW-1:0] centre_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < 3; i++) begin
        tap_r[i][0] <= tap_r[i][1];
        tap_r[i][1] <= tap_r[i][2];
      end
      tap_r[0][2] <= col_older;
      tap_r[1][2] <= col_newer;
      tap_r[2][2] <= col_pixel;
    end
  end

  // border taps fall to zero
  always_comb begin
    m[0][0] = (mask.top_ok && mask.left_ok)  ? tap_r[0][0] : '0;
    m[0][1] =  mask.top_ok                   ? tap_r[0][1] : '0;
    m[0][2] = (mask.top_ok && mask.right_ok) ? tap_r[0][2] : '0;
    m[1][0] =  mask.left_ok                  ? tap_r[1][0] : '0;
    m[1][1] =  tap_r[1][1];
    m[1][2] =  mask.right_ok                 ? tap_r[1][2] : '0;
    m[2][0] = (mask.bot_ok && mask.left_ok)  ? tap_r[2][0] : '0;
    m[2][1] =  mask.bot_ok                   ? tap_r[2][1] : '0;
    m[2][2] = (mask.bot_ok && mask.right_ok) ? tap_r[2][2] : '0;
    corner_nxt = (PW+2)'(m[0][0]) + (PW+2)'(m[0][2]) + (PW+2)'(m[2][0]) + (PW+2)'(m[2][2]);
    edge_nxt   = (PW+2)'(m[0][1]) + (PW+2)'(m[1][0]) + (PW+2)'(m[1][2]) + (PW+2)'(m[2][1]);
  end

  always_ff @(posedge clk) begin
    corner_r <= corner_nxt;
    edge_r   <= edge_nxt;
    centre_r <= m[1][1];
  end

  // corners x1, edges x2, centre x-12
  assign sum_o = OW'(corner_r) + (OW'(edge_r) <<< 1)
               - ((OW'(centre_r) <<< 3) + (OW'(centre_r) <<< 2));

endmodule

>>> rtl/lap3x3_out_fifo.sv
module lap3x3_out_fifo #(
  parameter int DW    = 45,
  parameter int DEPTH = 8,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic [DW-1:0] data_o,
  output logic [CW-1:0] count_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  assign data_o  = mem[rd_ptr_r];
  assign count_o = count_r;

endmodule

>>> rtl/laplacian_3x3_zero_pad_filter.sv
// 3x3 Laplacian filter (corners 1/4, edges 1/2, centre -3) over a raster stream of signed
// pixels with zero padding at the borders. Results come out exact in quarter units. After
// each frame the source sends image_width+1 pad beats; once image_width+1 beats have been
// accepted, every further input beat yields the result for the pixel image_width+1 beats
// earlier, and the frame's last pixel carries frame_last. The block takes one beat per
// clock while the output queue has credit: each beat reads both line stores at one column
// and writes them back in the next cycle, with the just-written column forwarded when the
// next beat hits it (widths of one). A result passes the line store read, the window shift
// and two adder stages, and waits in an eight-entry output queue so the input keeps
// flowing while the output stalls, until its credit runs out. A register write restarts
// the frame (width or height only) and is to be issued while the block is idle.
module laplacian_3x3_zero_pad_filter #(
  parameter int MAX_WIDTH  = 2048,
  parameter int PIXEL_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  lap3x3_in_if.sink   in_ch,
  lap3x3_out_if.source out_ch,
  lap3x3_cfg_if.sink  cfg_ch
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int RW    = lap3x3_pkg::ROW_W;
  localparam int HW    = lap3x3_pkg::IMG_H_BITS;
  localparam int XW    = lap3x3_pkg::X_W;
  localparam int YW    = lap3x3_pkg::Y_W;
  localparam int OW    = PIXEL_BITS + 5;
  localparam int FD    = lap3x3_pkg::FIFO_DEPTH;
  localparam int CW    = $clog2(FD + 1);
  localparam int DW    = OW + XW + YW + 1;

  logic [lap3x3_pkg::IMG_W_BITS-1:0] width_r;
  logic [HW-1:0]                     height_r;
  logic [WID_W-1:0]                  w_eff;
  logic [HW-1:0]                     h_eff;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;

  logic             in_acc;
  logic             cfg_acc;
  logic             c_nz;
  logic [COL_W-1:0] tx;
  logic [RW-1:0]    ty;
  logic [WID_W-1:0] c_plus;
  lap3x3_pkg::tag_t  tag;
  lap3x3_pkg::mask_t mask;
  logic signed [PIXEL_BITS-1:0] pix;

  logic                         s1_valid_r;
  logic [COL_W-1:0]             s1_addr_r;
  logic signed [PIXEL_BITS-1:0] s1_pix_r;
  lap3x3_pkg::tag_t             s1_tag_r;
  lap3x3_pkg::mask_t            s1_mask_r;
  logic                         s2_valid_r;
  lap3x3_pkg::tag_t             s2_tag_r;
  lap3x3_pkg::mask_t            s2_mask_r;
  logic                         s3_valid_r;
  lap3x3_pkg::tag_t             s3_tag_r;

  logic signed [PIXEL_BITS-1:0] col_older;
  logic signed [PIXEL_BITS-1:0] col_newer;
  logic signed [OW-1:0]         win_sum;
  logic [DW-1:0]                fifo_dout;
  logic [CW-1:0]                fifo_cnt;
  logic [CW:0]                  occupancy;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // effective frame size
  always_comb begin
    if (width_r == '0) begin
      w_eff = WID_W'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(width_r);
    end
    if (height_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_r) > lap3x3_pkg::MAX_HEIGHT) begin
      h_eff = HW'(lap3x3_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  // position of the pixel whose result this beat completes
  always_comb begin
    c_nz     = (col_r != '0);
    tx       = c_nz ? col_r - COL_W'(1) : COL_W'(w_eff - WID_W'(1));
    ty       = c_nz ? row_r - RW'(1) : row_r - RW'(2);
    tag.res  = (row_r >= RW'(2)) || ((row_r == RW'(1)) && c_nz);
    tag.last = (WID_W'(tx) == w_eff - WID_W'(1)) && (ty == h_eff - HW'(1));
    tag.x    = XW'(tx);
    tag.y    = YW'(ty);
    mask.top_ok   = (ty != '0);
    mask.bot_ok   = ((RW + 1)'(ty) + (RW + 1)'(1)) < (RW + 1)'(h_eff);
    mask.left_ok  = (tx != '0);
    mask.right_ok = (WID_W'(tx) + WID_W'(1)) < w_eff;
    pix    = in_ch.pad ? '0 : in_ch.pixel_value;
    c_plus = WID_W'(col_r) + WID_W'(1);
    if (tag.res && tag.last) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (c_plus >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_r != RW'(lap3x3_pkg::ROW_MAX)) ? row_r + RW'(1) : row_r;
    end else begin
      col_nxt = COL_W'(c_plus);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lap3x3_pkg::IMG_W_BITS'(lap3x3_pkg::RESET_WIDTH);
      height_r <= HW'(lap3x3_pkg::RESET_HEIGHT);
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_acc) begin
      case (cfg_ch.index)
        lap3x3_pkg::CFG_IMAGE_WIDTH: begin
          width_r <= cfg_ch.data[lap3x3_pkg::IMG_W_BITS-1:0];
          col_r   <= '0;
          row_r   <= '0;
        end
        lap3x3_pkg::CFG_IMAGE_HEIGHT: begin
          height_r <= cfg_ch.data[HW-1:0];
          col_r    <= '0;
          row_r    <= '0;
        end
        default: begin
          width_r <= width_r;
        end
      endcase
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // pipeline: read stores, shift window, partial sums, final sum into queue
  always_ff @(posedge clk) begin
    s1_addr_r <= col_r;
    s1_pix_r  <= pix;
    s1_tag_r  <= tag;
    s1_mask_r <= mask;
    s2_tag_r  <= s1_tag_r;
    s2_mask_r <= s1_mask_r;
    s3_tag_r  <= s2_tag_r;
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      s2_valid_r <= s1_valid_r && s1_tag_r.res;
      s3_valid_r <= s2_valid_r;
    end
  end

  lap3x3_line_buf #(
    .DEPTH (MAX_WIDTH),
    .PW    (PIXEL_BITS),
    .AW    (COL_W)
  ) u_line_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_addr  (col_r),
    .wr_en    (s1_valid_r),
    .wr_addr  (s1_addr_r),
    .wr_pixel (s1_pix_r),
    .older_o  (col_older),
    .newer_o  (col_newer)
  );

  lap3x3_window #(
    .PW (PIXEL_BITS),
    .OW (OW)
  ) u_window (
    .clk       (clk),
    .shift_en  (s1_valid_r),
    .col_older (col_older),
    .col_newer (col_newer),
    .col_pixel (s1_pix_r),
    .mask      (s2_mask_r),
    .sum_o     (win_sum)
  );

  lap3x3_out_fifo #(
    .DW    (DW),
    .DEPTH (FD),
    .CW    (CW)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s3_valid_r),
    .push_data ({win_sum, s3_tag_r.x, s3_tag_r.y, s3_tag_r.last}),
    .pop       (out_ch.valid && out_ch.ready),
    .data_o    (fifo_dout),
    .count_o   (fifo_cnt)
  );

  // credit for results still in flight
  assign occupancy = (CW + 1)'(fifo_cnt)
                   + (CW + 1)'(s1_valid_r && s1_tag_r.res)
                   + (CW + 1)'(s2_valid_r)
                   + (CW + 1)'(s3_valid_r);
  assign in_ch.ready = (occupancy < (CW + 1)'(FD));

  assign out_ch.valid          = (fifo_cnt != '0);
  assign out_ch.filtered_value = fifo_dout[DW-1 -: OW];
  assign out_ch.out_x          = fifo_dout[YW + XW -: XW];
  assign out_ch.out_y          = fifo_dout[YW -: YW];
  assign out_ch.frame_last     = fifo_dout[0];

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    occupancy <= (CW + 1)'(FD))
    else $error("result queue overcommitted");

  a_stage_order: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> $past(s1_valid_r))
    else $error("partial sum without a store read");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !cfg_acc && tag.res && tag.last) |=> (col_r == '0 && row_r == '0))
    else $error("frame did not restart after last pixel");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int PIX_BITS     = 16;
  localparam int OUT_BITS     = 21;
  localparam int MAX_COLS     = 2048;
  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 200;
  localparam int ITEM_TARGET  = 1300;
  localparam int TAIL_BEATS   = 40;
  localparam int REPORT_MAX   = 10;
  localparam int CORNER_WT    = 1;
  localparam int EDGE_WT      = 2;
  localparam int CENTRE_WT    = -12;
  localparam logic signed [PIX_BITS-1:0] PIX_MIN = 16'sh8000;
  localparam logic signed [PIX_BITS-1:0] PIX_MAX = 16'sh7fff;

  typedef struct {
    logic signed [OUT_BITS-1:0]     value;
    logic [lap3x3_pkg::X_W-1:0]     x;
    logic [lap3x3_pkg::Y_W-1:0]     y;
    logic                           last;
  } lap_result_t;

  class laplacian_scoreboard;
    logic [lap3x3_pkg::IMG_W_BITS-1:0] width_reg;
    logic [lap3x3_pkg::IMG_H_BITS-1:0] height_reg;
    logic signed [PIX_BITS-1:0]        older_row [MAX_COLS];
    logic signed [PIX_BITS-1:0]        newer_row [MAX_COLS];
    logic signed [PIX_BITS-1:0]        taps [3][3];
    int                                col;
    int                                row;
    int                                seen;
    int                                errors;
    lap_result_t                       awaited_responses [$];

    function new();
      width_reg  = lap3x3_pkg::IMG_W_BITS'(lap3x3_pkg::RESET_WIDTH);
      height_reg = lap3x3_pkg::IMG_H_BITS'(lap3x3_pkg::RESET_HEIGHT);
      foreach (older_row[i]) begin
        older_row[i] = '0;
        newer_row[i] = '0;
      end
      foreach (taps[i, j]) taps[i][j] = '0;
      col    = 0;
      row    = 0;
      seen   = 0;
      errors = 0;
    endfunction

    function int eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_COLS) return MAX_COLS;
      return int'(width_reg);
    endfunction

    function int eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > lap3x3_pkg::MAX_HEIGHT) return lap3x3_pkg::MAX_HEIGHT;
      return int'(height_reg);
    endfunction

    function void restart_frame();
      col  = 0;
      row  = 0;
      seen = 0;
    endfunction

    function void write_reg(logic [lap3x3_pkg::CFG_IDX_W-1:0] idx,
                            logic [lap3x3_pkg::CFG_DATA_W-1:0] data);
      if (idx == lap3x3_pkg::CFG_IMAGE_WIDTH) begin
        width_reg = data[lap3x3_pkg::IMG_W_BITS-1:0];
        restart_frame();
      end else if (idx == lap3x3_pkg::CFG_IMAGE_HEIGHT) begin
        height_reg = data[lap3x3_pkg::IMG_H_BITS-1:0];
        restart_frame();
      end
    endfunction

    // predicts the laplacian response for the pixel w+1 beats back
    function void take_pixel(logic signed [PIX_BITS-1:0] px, logic pad);
      int          w;
      int          h;
      int          tx;
      int          ty;
      int          acc;
      int          wt;
      int          i;
      int          j;
      lap_result_t r;
      w = eff_width();
      h = eff_height();
      for (i = 0; i < 3; i++) begin
        taps[i][0] = taps[i][1];
        taps[i][1] = taps[i][2];
      end
      taps[0][2]     = older_row[col];
      taps[1][2]     = newer_row[col];
      taps[2][2]     = pad ? '0 : px;
      older_row[col] = newer_row[col];
      newer_row[col] = taps[2][2];
      if (seen >= w + 1) begin
        if (col >= 1) begin
          tx = col - 1;
          ty = row - 1;
        end else begin
          tx = w - 1;
          ty = row - 2;
        end
        acc = 0;
        for (i = 0; i < 3; i++) begin
          for (j = 0; j < 3; j++) begin
            if ((i == 0 && ty == 0) || (i == 2 && ty + 1 >= h)) continue;
            if ((j == 0 && tx == 0) || (j == 2 && tx + 1 >= w)) continue;
            if (i == 1 && j == 1) wt = CENTRE_WT;
            else if (i == 1 || j == 1) wt = EDGE_WT;
            else wt = CORNER_WT;
            acc += wt * int'(taps[i][j]);
          end
        end
        r.value = OUT_BITS'(acc);
        r.x     = lap3x3_pkg::X_W'(tx);
        r.y     = lap3x3_pkg::Y_W'(ty);
        r.last  = (tx == w - 1) && (ty == h - 1);
        awaited_responses = {awaited_responses, r};
        if (r.last) begin
          restart_frame();
          return;
        end
      end
      seen++;
      if (col + 1 >= w) begin
        col = 0;
        if (row < lap3x3_pkg::ROW_MAX) row++;
      end else begin
        col++;
      end
    endfunction

    function void check_response(lap_result_t got);
      lap_result_t want;
      if (awaited_responses.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t: unexpected result value %0d x %0d y %0d last %0b", $realtime,
                   got.value, got.x, got.y, got.last);
        return;
      end
      want = awaited_responses.pop_front();
      if (got.value !== want.value || got.x !== want.x || got.y !== want.y ||
          got.last !== want.last) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display({"%0t: mismatch, expected value %0d x %0d y %0d last %0b,",
                    " got %0d x %0d y %0d last %0b"},
                   $realtime, want.value, want.x, want.y, want.last,
                   got.value, got.x, got.y, got.last);
      end
    endfunction

    function int pending();
      return awaited_responses.size();
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  lap3x3_in_if #(.PIXEL_BITS(PIX_BITS)) in_bus ();
  lap3x3_out_if #(.OUT_BITS(OUT_BITS)) out_bus ();
  lap3x3_cfg_if cfg_bus ();

  laplacian_3x3_zero_pad_filter #(
    .MAX_WIDTH (MAX_COLS),
    .PIXEL_BITS(PIX_BITS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus),
    .cfg_ch(cfg_bus)
  );

  laplacian_scoreboard sb;
  bit gaps_on      = 1'b1;
  bit hold_req     = 1'b0;
  int items_sent   = 0;
  int quiet_cycles = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic signed [PIX_BITS-1:0] rand_pixel();
    case ($urandom_range(0, 15))
      0: return PIX_MIN;
      1: return PIX_MAX;
      2: return '0;
      default: return PIX_BITS'($urandom);
    endcase
  endfunction

  task automatic send_beat(input logic signed [PIX_BITS-1:0] px, input logic pd);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.pixel_value <= px;
    in_bus.pad         <= pd;
    do @(posedge clk); while (!in_bus.ready);
    sb.take_pixel(px, pd);
    items_sent++;
  endtask

  // noisy frames flip the pad flag now and then, a cut frame stops early
  task automatic send_frame(input int w, input int h, input bit noisy, input int cut);
    int   total;
    int   k;
    logic pd;
    total = w * h + w + 1;
    if (cut > 0 && cut < total) total = cut;
    for (k = 0; k < total; k++) begin
      pd = (k >= w * h);
      if (noisy && $urandom_range(0, 9) == 0) pd = ~pd;
      send_beat(rand_pixel(), pd);
    end
  endtask

  task automatic go_idle();
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [lap3x3_pkg::CFG_IDX_W-1:0] idx,
                         input logic [lap3x3_pkg::CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    sb.write_reg(idx, data);
  endtask

  task automatic write_regs(input logic [lap3x3_pkg::CFG_DATA_W-1:0] wdata,
                            input logic [lap3x3_pkg::CFG_DATA_W-1:0] hdata,
                            input bit stray);
    if (stray)
      put_reg(lap3x3_pkg::CFG_IDX_W'($urandom_range(lap3x3_pkg::CFG_IMAGE_HEIGHT + 1,
                                                     (1 << lap3x3_pkg::CFG_IDX_W) - 1)),
              lap3x3_pkg::CFG_DATA_W'($urandom));
    put_reg(lap3x3_pkg::CFG_IMAGE_WIDTH, wdata);
    put_reg(lap3x3_pkg::CFG_IMAGE_HEIGHT, hdata);
    cfg_bus.valid <= 1'b0;
  endtask

  always @(posedge clk) begin : grab_result
    lap_result_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.value = out_bus.filtered_value;
      got.x     = out_bus.out_x;
      got.y     = out_bus.out_y;
      got.last  = out_bus.frame_last;
      sb.check_response(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("laplacian_3x3_zero_pad_filter test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side, with one long hold-off on request
  initial begin
    int stall;
    int run;
    out_bus.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = pick_gap();
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      run = $urandom_range(1, 24);
      repeat (run) @(posedge clk);
    end
  end

  initial begin
    int                                k;
    int                                w;
    int                                h;
    int                                cut;
    int                                frames;
    bit                                noisy;
    bit                                change;
    bit                                need_cfg;
    logic [lap3x3_pkg::CFG_DATA_W-1:0] wdata;
    logic [lap3x3_pkg::CFG_DATA_W-1:0] hdata;
    sb = new();
    in_bus.valid       <= 1'b0;
    in_bus.pixel_value <= '0;
    in_bus.pad         <= 1'b0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= lap3x3_pkg::CFG_IMAGE_WIDTH;
    cfg_bus.data       <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry, a partial frame just past the first row
    for (k = 0; k < lap3x3_pkg::RESET_WIDTH + 10; k++) send_beat(rand_pixel(), 1'b0);
    go_idle();

    // extreme centre against extreme neighbours, non-pad beat in the flush
    write_regs(3, 3, 1'b0);
    for (k = 0; k < 9; k++) send_beat((k == 4) ? PIX_MIN : PIX_MAX, 1'b0);
    send_beat(PIX_MIN, 1'b0);
    repeat (3) send_beat(PIX_MAX, 1'b1);
    go_idle();

    // zero geometry acts as one pixel, pad inside the frame, frames back to back
    write_regs('0, '0, 1'b1);
    send_beat(PIX_MAX, 1'b1);
    send_beat(PIX_MIN, 1'b1);
    send_beat(PIX_MAX, 1'b1);
    send_beat(PIX_MIN, 1'b0);
    send_beat(PIX_MAX, 1'b1);
    send_beat(PIX_MIN, 1'b1);
    go_idle();

    frames   = 0;
    need_cfg = 1'b1;
    w        = 1;
    h        = 1;
    while (items_sent < ITEM_TARGET - 2 * TAIL_BEATS || frames < 4) begin
      frames++;
      gaps_on = ($urandom_range(0, 4) != 0);
      change  = need_cfg || ($urandom_range(0, 9) < 4);
      if (frames == 4) begin
        w        = 16;
        h        = 16;
        change   = 1'b1;
        gaps_on  = 1'b0;
      end else if (change) begin
        case ($urandom_range(0, 9))
          0: w = 0;
          1: w = $urandom_range(17, 64);
          default: w = $urandom_range(1, 16);
        endcase
        case ($urandom_range(0, 9))
          0: h = 0;
          1: h = $urandom_range(13, 24);
          default: h = $urandom_range(1, 12);
        endcase
      end
      if (change) begin
        wdata = {4'($urandom), 12'(w)};
        hdata = {3'($urandom), 13'(h)};
        go_idle();
        write_regs(wdata, hdata, $urandom_range(0, 5) == 0);
      end
      if (frames == 4) hold_req = 1'b1;
      noisy = ($urandom_range(0, 6) == 0);
      cut   = 0;
      if ($urandom_range(0, 9) == 0)
        cut = $urandom_range(1, sb.eff_width() * sb.eff_height() + sb.eff_width());
      send_frame(sb.eff_width(), sb.eff_height(), noisy, cut);
      need_cfg = (cut != 0);
      if ($urandom_range(0, 7) == 0) go_idle();
    end

    // widest and tallest geometries, clamped, short partial frames
    gaps_on = 1'b1;
    go_idle();
    write_regs(16'hffff, 1, 1'b0);
    send_frame(sb.eff_width(), sb.eff_height(), 1'b0, TAIL_BEATS);
    go_idle();
    write_regs(1, 16'hffff, 1'b0);
    send_frame(sb.eff_width(), sb.eff_height(), 1'b0, TAIL_BEATS);
    go_idle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("laplacian_3x3_zero_pad_filter test passed");
    end else begin
      $display("laplacian_3x3_zero_pad_filter test failed");
    end
    $finish;
  end

endmodule
